FILE: src/cdeq_pkg.sv
// Shared request and status codes and the cell control struct for the deque.
package cdeq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned StW   = 2;

  // Request codes; the undefined codes five to seven act as no operation
  localparam logic [ReqW-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [ReqW-1:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [ReqW-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [ReqW-1:0] REQ_POP_REAR   = 3'd3;
  localparam logic [ReqW-1:0] REQ_NOP        = 3'd4;

  // Status codes
  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_FULL  = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY = 2'd2;

  // Per-row control shared by every cell of one chain
  typedef struct packed {
    logic shr;  // shift towards higher cells, cell 0 takes the new word
    logic shl;  // shift towards cell 0, top cell takes zero
    logic wr;   // write the new word at the cell whose place equals the count
  } cdeq_ctrl_t;

endpackage

FILE: src/cdeq_cell.sv
// One storage cell of a deque chain: holds a word and trades it with its neighbours.
module cdeq_cell #(
  parameter int unsigned CntW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic                      clk_i,
  input  cdeq_pkg::cdeq_ctrl_t      ctrl_i,
  input  logic [CntW-1:0]           wr_at_i,
  input  logic [cdeq_pkg::DataW-1:0] wr_word_i,
  input  logic [cdeq_pkg::DataW-1:0] lower_i,
  input  logic [cdeq_pkg::DataW-1:0] upper_i,
  output logic [cdeq_pkg::DataW-1:0] word_o
);
  import cdeq_pkg::*;

  logic [DataW-1:0] word_d, word_q;

  // Shift from a neighbour, take a positional write, or hold
  always_comb begin
    if (ctrl_i.shr) begin
      word_d = lower_i;
    end else if (ctrl_i.shl) begin
      word_d = upper_i;
    end else if (ctrl_i.wr && (wr_at_i == CntW'(Idx))) begin
      word_d = wr_word_i;
    end else begin
      word_d = word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

FILE: src/circular_double_ended_queue.sv
// Fixed-capacity double-ended queue built from two mirrored chains of cells.
//
//  channel | direction | handshake                | words
//  --------+-----------+--------------------------+------------------------------------------
//  request | in        | in_valid_i / in_ready_o  | req_type_i, push_value_i
//  result  | out       | out_valid_o / out_ready_i| status_o, popped_value_o, front_value_o,
//          |           |                          | rear_value_o, occupancy_o, is_empty_o,
//          |           |                          | is_full_o
//
// One request is taken per cycle while the result register is empty or being emptied;
// its result appears in the output register on the next cycle. The front chain keeps
// the front element in cell 0 and the rear chain keeps the rear element in its cell 0,
// so both ends are read at fixed cells and every request completes in a single step of the cell rows.
// Reset clears the count and the output valid; cell contents need no reset.
// A new request is taken while the result register is empty or being emptied.
module circular_double_ended_queue #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cdeq_pkg::ReqW-1:0]        req_type_i,
  input  logic signed [cdeq_pkg::DataW-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cdeq_pkg::StW-1:0]         status_o,
  output logic signed [cdeq_pkg::DataW-1:0] popped_value_o,
  output logic signed [cdeq_pkg::DataW-1:0] front_value_o,
  output logic signed [cdeq_pkg::DataW-1:0] rear_value_o,
  output logic [$clog2(CAPACITY + 1)-1:0]  occupancy_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);
  import cdeq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [DataW-1:0] front_row [CAPACITY];
  logic [DataW-1:0] rear_row  [CAPACITY];
  logic [DataW-1:0] new_word;

  cdeq_ctrl_t front_ctrl, rear_ctrl;

  logic [CntW-1:0] cnt_d, cnt_q;
  logic            acc, full, empty;
  logic            is_push, is_pop, at_front;
  logic            push_ok, pop_ok;
  logic [StW-1:0]  status_d;
  logic [DataW-1:0] popped_d, front_d, rear_d;

  logic             out_valid_d, out_valid_q;
  logic [StW-1:0]   status_q;
  logic [DataW-1:0] popped_q, front_q, rear_q;
  logic [CntW-1:0]  occ_q;

  assign new_word = push_value_i;
  assign acc      = in_valid_i & in_ready_o;
  assign full     = (cnt_q == CntW'(CAPACITY));
  assign empty    = (cnt_q == '0);

  // Request decode
  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    at_front = 1'b0;
    unique case (req_type_i)
      REQ_PUSH_FRONT: begin
        is_push  = 1'b1;
        at_front = 1'b1;
      end
      REQ_PUSH_REAR: begin
        is_push = 1'b1;
      end
      REQ_POP_FRONT: begin
        is_pop   = 1'b1;
        at_front = 1'b1;
      end
      REQ_POP_REAR: begin
        is_pop = 1'b1;
      end
      default: begin
        is_push = 1'b0;
      end
    endcase
  end

  assign push_ok = acc & is_push & ~full;
  assign pop_ok  = acc & is_pop & ~empty;

  // Front chain shifts on front-end traffic, takes a positional write on push rear
  assign front_ctrl.shr = push_ok & at_front;
  assign front_ctrl.shl = pop_ok & at_front;
  assign front_ctrl.wr  = push_ok & ~at_front;
  // Rear chain mirrors it
  assign rear_ctrl.shr  = push_ok & ~at_front;
  assign rear_ctrl.shl  = pop_ok & ~at_front;
  assign rear_ctrl.wr   = push_ok & at_front;

  // Two rows of cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cells
    logic [DataW-1:0] f_lo, f_hi, r_lo, r_hi;
    if (k == 0) begin : g_first
      assign f_lo = new_word;
      assign r_lo = new_word;
    end else begin : g_mid
      assign f_lo = front_row[k-1];
      assign r_lo = rear_row[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign f_hi = '0;
      assign r_hi = '0;
    end else begin : g_inner
      assign f_hi = front_row[k+1];
      assign r_hi = rear_row[k+1];
    end

    cdeq_cell #(.CntW(CntW), .Idx(k)) u_front_cell (
      .clk_i     (clk_i),
      .ctrl_i    (front_ctrl),
      .wr_at_i   (cnt_q),
      .wr_word_i (new_word),
      .lower_i   (f_lo),
      .upper_i   (f_hi),
      .word_o    (front_row[k])
    );

    cdeq_cell #(.CntW(CntW), .Idx(k)) u_rear_cell (
      .clk_i     (clk_i),
      .ctrl_i    (rear_ctrl),
      .wr_at_i   (cnt_q),
      .wr_word_i (new_word),
      .lower_i   (r_lo),
      .upper_i   (r_hi),
      .word_o    (rear_row[k])
    );
  end

  // Occupancy update
  always_comb begin
    if (push_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  // Result word, built from the state as it stands after the step
  always_comb begin
    status_d = ST_OK;
    if (is_push && full) begin
      status_d = ST_FULL;
    end else if (is_pop && empty) begin
      status_d = ST_EMPTY;
    end

    popped_d = '0;
    if (pop_ok) begin
      popped_d = at_front ? front_row[0] : rear_row[0];
    end

    if (cnt_d == '0) begin
      front_d = '0;
    end else if (push_ok && (at_front || empty)) begin
      front_d = new_word;
    end else if (pop_ok && at_front) begin
      front_d = front_row[1];
    end else begin
      front_d = front_row[0];
    end

    if (cnt_d == '0) begin
      rear_d = '0;
    end else if (push_ok && (!at_front || empty)) begin
      rear_d = new_word;
    end else if (pop_ok && !at_front) begin
      rear_d = rear_row[1];
    end else begin
      rear_d = rear_row[0];
    end
  end

  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign out_valid_d = acc | (out_valid_q & ~out_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      popped_q <= popped_d;
      front_q  <= front_d;
      rear_q   <= rear_d;
      occ_q    <= cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign front_value_o  = front_q;
  assign rear_value_o   = rear_q;
  assign occupancy_o    = occ_q;
  assign is_empty_o     = (occ_q == '0);
  assign is_full_o      = (occ_q == CntW'(CAPACITY));

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the circular double-ended queue: random and directed words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cdeq_pkg::*;

  localparam int unsigned Capacity   = 8;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CntW       = 4;
  localparam int unsigned RandWords  = 1650;
  localparam int unsigned PhaseLen   = 120;
  localparam int unsigned DrainCyc   = 6;
  localparam int unsigned CycleLimit = 400000;

  // Idle phases
  typedef enum logic [1:0] {
    PH_NONE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  // Traffic mix used by the random part
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_e;

  typedef struct packed {
    logic [ReqW-1:0]  req;
    logic [DataW-1:0] value;
  } deque_req_t;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic [DataW-1:0] popped;
    logic [DataW-1:0] front;
    logic [DataW-1:0] rear;
    logic [CntW-1:0]  occupancy;
    logic             empty;
    logic             full;
  } deque_result_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [ReqW-1:0]          req_type_i     = REQ_NOP;
  logic signed [DataW-1:0]  push_value_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [StW-1:0]           status_o;
  logic signed [DataW-1:0]  popped_value_o;
  logic signed [DataW-1:0]  front_value_o;
  logic signed [DataW-1:0]  rear_value_o;
  logic [CntW-1:0]          occupancy_o;
  logic                     is_empty_o;
  logic                     is_full_o;

  deque_req_t    pending_words[$];
  deque_result_t expected_results[$];
  idle_phase_e   idle_phase  = PH_NONE;
  int unsigned   words_sent  = 0;
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;

  // Shadow copy of the deque
  logic [DataW-1:0] shadow_slots[Capacity];
  logic [IdxW-1:0]  shadow_head = '0;
  logic [IdxW-1:0]  shadow_tail = '0;
  logic [CntW-1:0]  shadow_count = '0;

  circular_double_ended_queue #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .occupancy_o   (occupancy_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one request to the shadow deque and return the result it should give
  function automatic deque_result_t deque_apply(logic [ReqW-1:0] req, logic [DataW-1:0] value);
    deque_result_t res;
    logic          was_full;
    logic          was_empty;
    res       = '0;
    res.status = ST_OK;
    was_full  = (shadow_count == Capacity);
    was_empty = (shadow_count == 0);
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (was_full) begin
          res.status = ST_FULL;
        end else begin
          if (was_empty) begin
            shadow_head     = '0;
            shadow_tail     = '0;
            shadow_slots[0] = value;
          end else if (req == REQ_PUSH_FRONT) begin
            shadow_head               = shadow_head - 1'b1;
            shadow_slots[shadow_head] = value;
          end else begin
            shadow_tail               = shadow_tail + 1'b1;
            shadow_slots[shadow_tail] = value;
          end
          shadow_count = shadow_count + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_REAR: begin
        if (was_empty) begin
          res.status = ST_EMPTY;
        end else begin
          if (req == REQ_POP_FRONT) begin
            res.popped  = shadow_slots[shadow_head];
            shadow_head = shadow_head + 1'b1;
          end else begin
            res.popped  = shadow_slots[shadow_tail];
            shadow_tail = shadow_tail - 1'b1;
          end
          shadow_count = shadow_count - 1'b1;
          // last element gone: both ends back to slot 0
          if (shadow_count == 0) begin
            shadow_head = '0;
            shadow_tail = '0;
          end
        end
      end
      default: ;  // no operation, undefined codes included
    endcase
    res.empty     = (shadow_count == 0);
    res.full      = (shadow_count == Capacity);
    res.occupancy = shadow_count;
    res.front     = res.empty ? '0 : shadow_slots[shadow_head];
    res.rear      = res.empty ? '0 : shadow_slots[shadow_tail];
    return res;
  endfunction

  function automatic int unsigned sender_idle_pct(idle_phase_e ph);
    case (ph)
      PH_SEND_IDLE: return 74;
      PH_BOTH:      return 7;
      default:      return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(idle_phase_e ph);
    case (ph)
      PH_RECV_STALL: return 74;
      PH_BOTH:       return 7;
      default:       return 0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [DataW-1:0] exp_v,
                                      logic [DataW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ReqW-1:0] pick_req(traffic_mix_e mix);
    int unsigned roll;
    int unsigned push_pct;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  push_pct = 66;
      MIX_DRAIN: push_pct = 27;
      default:   push_pct = 47;
    endcase
    if (roll < push_pct) return $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
    if (roll < 93) return $urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT;
    // no operation or one of the undefined codes
    return ReqW'(REQ_NOP + $urandom_range(3));
  endfunction

  // Request driver: holds each word until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= REQ_NOP;
      push_value_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(deque_apply(req_type_i, push_value_i));
        words_sent++;
        idle_phase <= idle_phase_e'((words_sent / PhaseLen) % 4);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct(idle_phase)) begin
          in_valid_i   <= 1'b1;
          req_type_i   <= pending_words[0].req;
          push_value_i <= pending_words[0].value;
          pending_words.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual status %0h",
                   $realtime, status_o);
          error_count++;
        end else begin
          exp_r = expected_results[0];
          expected_results.delete(0);
          check_field("status",       exp_r.status,    status_o);
          check_field("popped_value", exp_r.popped,    popped_value_o);
          check_field("front_value",  exp_r.front,     front_value_o);
          check_field("rear_value",   exp_r.rear,      rear_value_o);
          check_field("occupancy",    exp_r.occupancy, occupancy_o);
          check_field("is_empty",     exp_r.empty,     is_empty_o);
          check_field("is_full",      exp_r.full,      is_full_o);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct(idle_phase));
    end
  end

  // Run-length guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** circular_double_ended_queue: FAILED **");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    traffic_mix_e mix;
    int unsigned  seg_left;
    deque_req_t   w;
    // directed: empty pops, last-element pops both ways, fill, full pushes, odd codes
    pending_words.push_back('{REQ_POP_FRONT,  32'h1234_5678});
    pending_words.push_back('{REQ_POP_REAR,   32'hffff_ffff});
    pending_words.push_back('{REQ_NOP,        32'h0});
    pending_words.push_back('{REQ_PUSH_FRONT, 32'h8000_0000});
    pending_words.push_back('{REQ_POP_REAR,   32'h0});
    pending_words.push_back('{REQ_PUSH_REAR,  32'h7fff_ffff});
    pending_words.push_back('{REQ_POP_FRONT,  32'h0});
    pending_words.push_back('{REQ_PUSH_FRONT, 32'h0000_0000});
    pending_words.push_back('{REQ_PUSH_REAR,  32'hffff_ffff});
    pending_words.push_back('{REQ_PUSH_FRONT, 32'h0000_0001});
    pending_words.push_back('{REQ_PUSH_REAR,  32'h5555_5555});
    pending_words.push_back('{REQ_PUSH_FRONT, 32'haaaa_aaaa});
    pending_words.push_back('{REQ_PUSH_REAR,  32'h0000_0002});
    pending_words.push_back('{REQ_PUSH_FRONT, 32'h8000_0000});
    pending_words.push_back('{REQ_PUSH_REAR,  32'h7fff_ffff});
    pending_words.push_back('{REQ_PUSH_FRONT, 32'hdead_beef});
    pending_words.push_back('{REQ_PUSH_REAR,  32'hcafe_f00d});
    pending_words.push_back('{REQ_NOP + 3'd1, 32'hffff_ffff});
    pending_words.push_back('{REQ_NOP + 3'd2, 32'h0});
    pending_words.push_back('{REQ_NOP + 3'd3, 32'h1});
    pending_words.push_back('{REQ_POP_FRONT,  32'h0});
    pending_words.push_back('{REQ_POP_REAR,   32'h0});

    // random: stretches biased to fill or drain so both ends are hit often
    seg_left = 0;
    mix      = MIX_EVEN;
    for (int unsigned n = 0; n < RandWords; n++) begin
      if (seg_left == 0) begin
        mix      = traffic_mix_e'($urandom_range(2));
        seg_left = $urandom_range(40, 10);
      end
      seg_left--;
      w.req   = pick_req(mix);
      w.value = pick_value();
      pending_words.push_back(w);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** circular_double_ended_queue: PASSED **");
    end else begin
      $display("** circular_double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cdeq_pkg.sv
src/cdeq_cell.sv
src/circular_double_ended_queue.sv
tb/sv/testbench.sv
